// File: src/plb_pkg.sv
// plb_pkg: shared constants, codes and types for the price level book
// no dependencies
package plb_pkg;

    localparam int unsigned LEVELS_DEF = 64;
    localparam int unsigned PRICE_W    = 32;
    localparam int unsigned QTY_W      = 48;
    localparam int unsigned DEPTH_W    = 5;
    localparam int unsigned SUM_W      = 33;

    localparam logic [1:0] REQ_CLEAR  = 2'd0;
    localparam logic [1:0] REQ_SNAP   = 2'd1;
    localparam logic [1:0] REQ_UPDATE = 2'd2;
    localparam logic [1:0] REQ_QUERY  = 2'd3;

    localparam logic [1:0] ACT_NEW    = 2'd0;
    localparam logic [1:0] ACT_CHANGE = 2'd1;
    localparam logic [1:0] ACT_DELETE = 2'd2;

    localparam logic [1:0] KIND_ACK = 2'd0;
    localparam logic [1:0] KIND_BID = 2'd1;
    localparam logic [1:0] KIND_ASK = 2'd2;
    localparam logic [1:0] KIND_SUM = 2'd3;

    localparam logic [1:0] OP_NONE   = 2'd0;
    localparam logic [1:0] OP_STORE  = 2'd1;
    localparam logic [1:0] OP_ERASE  = 2'd2;
    localparam logic [1:0] OP_CLEAR  = 2'd3;

    // command broadcast to every cell of one side
    typedef struct packed {
        logic [1:0]         op;
        logic [PRICE_W-1:0] price;
        logic [QTY_W-1:0]   qty;
        logic               shift;
    } t_cell_cmd;

    typedef struct packed {
        logic [1:0]         item_kind;
        logic               status;
        logic [DEPTH_W-1:0] level_index;
        logic [PRICE_W-1:0] level_price;
        logic [QTY_W-1:0]   level_qty;
        logic [SUM_W-1:0]   spread;
        logic [SUM_W-1:0]   mid_doubled;
        logic               last;
    } t_result;

endpackage

// File: src/plb_if.sv
// plb_if: request and result channels with valid/ready handshake
// depends on plb_pkg
interface plb_req_if;
    logic                         valid;
    logic                         ready;
    logic [1:0]                   req_type;
    logic                         side;
    logic [plb_pkg::PRICE_W-1:0]  price;
    logic [plb_pkg::QTY_W-1:0]    qty;
    logic [1:0]                   action;
    logic [plb_pkg::DEPTH_W-1:0]  depth;
    modport source (output valid, req_type, side, price, qty, action, depth, input ready);
    modport sink   (input valid, req_type, side, price, qty, action, depth, output ready);
endinterface

interface plb_res_if;
    logic                         valid;
    logic                         ready;
    logic [1:0]                   item_kind;
    logic                         status;
    logic [plb_pkg::DEPTH_W-1:0]  level_index;
    logic [plb_pkg::PRICE_W-1:0]  level_price;
    logic [plb_pkg::QTY_W-1:0]    level_qty;
    logic [plb_pkg::SUM_W-1:0]    spread;
    logic [plb_pkg::SUM_W-1:0]    mid_doubled;
    logic                         last;
    modport source (output valid, item_kind, status, level_index, level_price, level_qty,
                    spread, mid_doubled, last, input ready);
    modport sink   (input valid, item_kind, status, level_index, level_price, level_qty,
                    spread, mid_doubled, last, output ready);
endinterface

// File: src/plb_cell.sv
// plb_cell: one level slot of a sorted side, with valid flag
// depends on plb_pkg
module plb_cell (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_side,
    input  plb_pkg::t_cell_cmd          i_cmd,
    input  logic                        i_prev_valid,
    input  logic                        i_prev_ahead,
    input  logic [plb_pkg::PRICE_W-1:0] i_prev_price,
    input  logic [plb_pkg::QTY_W-1:0]   i_prev_qty,
    input  logic                        i_next_valid,
    input  logic [plb_pkg::PRICE_W-1:0] i_next_price,
    input  logic [plb_pkg::QTY_W-1:0]   i_next_qty,
    output logic                        o_valid,
    output logic                        o_ahead,
    output logic                        o_match,
    output logic [plb_pkg::PRICE_W-1:0] o_price,
    output logic [plb_pkg::QTY_W-1:0]   o_qty
);
    import plb_pkg::*;

    logic               r_valid;
    logic [PRICE_W-1:0] r_price;
    logic [QTY_W-1:0]   r_qty;
    logic               n_valid;
    logic [PRICE_W-1:0] n_price;
    logic [QTY_W-1:0]   n_qty;
    logic               w_ahead;
    logic               w_match;
    logic               w_prev_at;

    assign w_ahead   = r_valid && (i_side ? (r_price < i_cmd.price) : (r_price > i_cmd.price));
    assign w_match   = r_valid && (r_price == i_cmd.price);
    // prev cell is at or past the match point
    assign w_prev_at = !i_prev_ahead;

    always_comb begin
        n_valid = r_valid;
        n_price = r_price;
        n_qty   = r_qty;
        case (i_cmd.op)
            OP_CLEAR: begin
                n_valid = 1'b0;
            end
            OP_STORE: begin
                if (w_match) begin
                    n_qty = i_cmd.qty;
                end else if (i_cmd.shift && !w_ahead && i_prev_ahead) begin
                    n_valid = 1'b1;
                    n_price = i_cmd.price;
                    n_qty   = i_cmd.qty;
                end else if (i_cmd.shift && !w_ahead && w_prev_at && i_prev_valid) begin
                    n_valid = i_prev_valid;
                    n_price = i_prev_price;
                    n_qty   = i_prev_qty;
                end
            end
            OP_ERASE: begin
                if (i_cmd.shift && r_valid && !w_ahead) begin
                    n_valid = i_next_valid;
                    n_price = i_next_price;
                    n_qty   = i_next_qty;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_price <= n_price;
        r_qty   <= n_qty;
    end

    assign o_valid = r_valid;
    assign o_ahead = w_ahead;
    assign o_match = w_match;
    assign o_price = r_price;
    assign o_qty   = r_qty;
endmodule

// File: src/plb_side.sv
// plb_side: chain of level cells for one side, with count and read mux
// depends on plb_pkg, plb_cell
module plb_side #(
    parameter int unsigned LEVELS = plb_pkg::LEVELS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_side,
    input  plb_pkg::t_cell_cmd          i_cmd,
    input  logic [plb_pkg::DEPTH_W-1:0] i_rd_idx,
    output logic                        o_any_match,
    output logic                        o_full,
    output logic [$clog2(LEVELS):0]     o_count,
    output logic [plb_pkg::PRICE_W-1:0] o_rd_price,
    output logic [plb_pkg::QTY_W-1:0]   o_rd_qty
);
    import plb_pkg::*;

    logic [LEVELS-1:0]  w_valid;
    logic [LEVELS-1:0]  w_ahead;
    logic [LEVELS-1:0]  w_match;
    logic [PRICE_W-1:0] w_price [LEVELS];
    logic [QTY_W-1:0]   w_qty   [LEVELS];
    logic [$clog2(LEVELS):0] r_count;

    for (genvar g = 0; g < LEVELS; g++) begin : g_cell
        logic               w_pv, w_pa, w_nv;
        logic [PRICE_W-1:0] w_pp, w_np;
        logic [QTY_W-1:0]   w_pq, w_nq;
        if (g == 0) begin : g_first
            assign w_pv = 1'b1;
            assign w_pa = 1'b1;
            assign w_pp = '0;
            assign w_pq = '0;
        end else begin : g_mid
            assign w_pv = w_valid[g-1];
            assign w_pa = w_ahead[g-1];
            assign w_pp = w_price[g-1];
            assign w_pq = w_qty[g-1];
        end
        if (g == LEVELS - 1) begin : g_end
            assign w_nv = 1'b0;
            assign w_np = '0;
            assign w_nq = '0;
        end else begin : g_nxt
            assign w_nv = w_valid[g+1];
            assign w_np = w_price[g+1];
            assign w_nq = w_qty[g+1];
        end
        plb_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_side       (i_side),
            .i_cmd        (i_cmd),
            .i_prev_valid (w_pv),
            .i_prev_ahead (w_pa),
            .i_prev_price (w_pp),
            .i_prev_qty   (w_pq),
            .i_next_valid (w_nv),
            .i_next_price (w_np),
            .i_next_qty   (w_nq),
            .o_valid      (w_valid[g]),
            .o_ahead      (w_ahead[g]),
            .o_match      (w_match[g]),
            .o_price      (w_price[g]),
            .o_qty        (w_qty[g])
        );
    end

    assign o_any_match = |w_match;
    assign o_full      = w_valid[LEVELS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            case (i_cmd.op)
                OP_CLEAR: r_count <= '0;
                OP_STORE: if (i_cmd.shift) r_count <= r_count + 1'b1;
                OP_ERASE: if (i_cmd.shift) r_count <= r_count - 1'b1;
                default: begin
                end
            endcase
        end
    end

    assign o_count = r_count;

    // only the top 32 ranks are ever reported
    always_comb begin
        o_rd_price = '0;
        o_rd_qty   = '0;
        for (int k = 0; k < 32; k++) begin
            if (k < LEVELS && i_rd_idx == DEPTH_W'(k)) begin
                o_rd_price = w_price[k % LEVELS];
                o_rd_qty   = w_qty[k % LEVELS];
            end
        end
    end
endmodule

// File: src/price_level_book.sv
// price_level_book: two sorted price level chains with request sequencer
// depends on plb_pkg, plb_if, plb_side, plb_cell
// clear, snapshot and update requests run in a single exec state (match and shift together);
// the acknowledge is registered from that state, and no new request is taken until back in idle.
// a query reports nb bid and na ask levels and then a summary, with a turnaround step that emits
// nothing between sides; stalled results hold the input and no request is taken until idle.
// reset: synchronous active low clears level counts, valid flags and the sequencer.
module price_level_book #(
    parameter int unsigned LEVELS = plb_pkg::LEVELS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    plb_req_if.sink   i_req,
    plb_res_if.source o_res
);
    import plb_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_QBID = 2'd2;
    localparam logic [1:0] ST_QASK = 2'd3;
    localparam int unsigned CW = $clog2(LEVELS) + 1;
    localparam int unsigned NW = (CW > DEPTH_W) ? CW : DEPTH_W;

    logic [1:0]         r_state;
    logic [1:0]         r_req_type;
    logic               r_side;
    logic [PRICE_W-1:0] r_price;
    logic [QTY_W-1:0]   r_qty;
    logic [1:0]         r_action;
    logic [DEPTH_W-1:0] r_depth;
    logic [DEPTH_W-1:0] r_idx;
    logic               r_out_valid;
    t_result            r_out;
    logic [PRICE_W-1:0] r_best_bid;
    logic               r_have_bid;
    logic [PRICE_W-1:0] r_best_ask;
    logic               r_have_ask;

    logic [1:0]         n_state;
    logic [DEPTH_W-1:0] n_idx;
    logic               n_out_valid;
    t_result            n_out;
    logic [PRICE_W-1:0] n_best_bid;
    logic               n_have_bid;
    logic [PRICE_W-1:0] n_best_ask;
    logic               n_have_ask;

    t_cell_cmd          w_cmd_b, w_cmd_a;
    logic               w_match_b, w_match_a, w_full_b, w_full_a;
    logic [CW-1:0]      w_cnt_b, w_cnt_a;
    logic [PRICE_W-1:0] w_pr_b, w_pr_a;
    logic [QTY_W-1:0]   w_q_b, w_q_a;
    logic               w_out_free;
    logic               w_store, w_erase, w_match, w_full;
    logic [DEPTH_W-1:0] w_nb, w_na;
    logic [SUM_W-1:0]   w_ask_ext, w_bid_ext;

    assign w_out_free  = !r_out_valid || o_res.ready;
    assign i_req.ready = (r_state == ST_IDLE) && w_out_free;

    assign w_store = (r_req_type == REQ_SNAP) ||
                     ((r_req_type == REQ_UPDATE) && (r_action != ACT_DELETE) &&
                      (r_qty != '0) && ((r_action == ACT_NEW) || (r_action == ACT_CHANGE)));
    assign w_erase = (r_req_type == REQ_UPDATE) &&
                     ((r_action == ACT_DELETE) || (r_qty == '0));
    assign w_match = r_side ? w_match_a : w_match_b;
    assign w_full  = r_side ? w_full_a : w_full_b;

    always_comb begin
        w_cmd_b       = '0;
        w_cmd_b.price = r_price;
        w_cmd_b.qty   = r_qty;
        if (r_state == ST_EXEC) begin
            if (r_req_type == REQ_CLEAR) begin
                w_cmd_b.op = OP_CLEAR;
            end else if (w_store) begin
                w_cmd_b.op    = OP_STORE;
                w_cmd_b.shift = !w_match && !w_full;
            end else if (w_erase) begin
                w_cmd_b.op    = OP_ERASE;
                w_cmd_b.shift = w_match;
            end
        end
        w_cmd_a = w_cmd_b;
        if (r_req_type != REQ_CLEAR) begin
            if (r_side) w_cmd_b.op = OP_NONE;
            else        w_cmd_a.op = OP_NONE;
        end
    end

    plb_side #(.LEVELS(LEVELS)) u_bid (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_side(1'b0), .i_cmd(w_cmd_b),
        .i_rd_idx(r_idx), .o_any_match(w_match_b), .o_full(w_full_b),
        .o_count(w_cnt_b), .o_rd_price(w_pr_b), .o_rd_qty(w_q_b)
    );
    plb_side #(.LEVELS(LEVELS)) u_ask (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_side(1'b1), .i_cmd(w_cmd_a),
        .i_rd_idx(r_idx), .o_any_match(w_match_a), .o_full(w_full_a),
        .o_count(w_cnt_a), .o_rd_price(w_pr_a), .o_rd_qty(w_q_a)
    );

    assign w_nb = (NW'(w_cnt_b) < NW'(r_depth)) ? DEPTH_W'(w_cnt_b) : r_depth;
    assign w_na = (NW'(w_cnt_a) < NW'(r_depth)) ? DEPTH_W'(w_cnt_a) : r_depth;
    assign w_ask_ext = {1'b0, r_best_ask};
    assign w_bid_ext = {1'b0, r_best_bid};

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_out_valid = r_out_valid && !o_res.ready;
        n_out       = r_out;
        n_best_bid  = r_best_bid;
        n_have_bid  = r_have_bid;
        n_best_ask  = r_best_ask;
        n_have_ask  = r_have_ask;
        case (r_state)
            ST_IDLE: begin
                if (i_req.valid && i_req.ready) begin
                    n_idx      = '0;
                    n_have_bid = 1'b0;
                    n_have_ask = 1'b0;
                    n_state    = (i_req.req_type == REQ_QUERY) ? ST_QBID : ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_out_valid    = 1'b1;
                n_out          = '0;
                n_out.item_kind = KIND_ACK;
                n_out.status    = w_store && !w_match && w_full;
                n_out.last      = 1'b1;
                n_state         = ST_IDLE;
            end
            ST_QBID: begin
                if (w_out_free) begin
                    if (r_idx < w_nb) begin
                        n_out_valid       = 1'b1;
                        n_out             = '0;
                        n_out.item_kind   = KIND_BID;
                        n_out.level_index = r_idx;
                        n_out.level_price = w_pr_b;
                        n_out.level_qty   = w_q_b;
                        if (r_idx == '0) begin
                            n_best_bid = w_pr_b;
                            n_have_bid = 1'b1;
                        end
                        n_idx = r_idx + 1'b1;
                    end else begin
                        n_idx   = '0;
                        n_state = ST_QASK;
                    end
                end
            end
            ST_QASK: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = '0;
                    if (r_idx < w_na) begin
                        n_out.item_kind   = KIND_ASK;
                        n_out.level_index = r_idx;
                        n_out.level_price = w_pr_a;
                        n_out.level_qty   = w_q_a;
                        if (r_idx == '0) begin
                            n_best_ask = w_pr_a;
                            n_have_ask = 1'b1;
                        end
                        n_idx = r_idx + 1'b1;
                    end else begin
                        n_out.item_kind = KIND_SUM;
                        n_out.last      = 1'b1;
                        if (r_have_bid && r_have_ask) begin
                            n_out.spread      = w_ask_ext - w_bid_ext;
                            n_out.mid_doubled = w_ask_ext + w_bid_ext;
                        end
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_have_bid  <= 1'b0;
            r_have_ask  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_have_bid  <= n_have_bid;
            r_have_ask  <= n_have_ask;
        end
        r_out      <= n_out;
        r_idx      <= n_idx;
        r_best_bid <= n_best_bid;
        r_best_ask <= n_best_ask;
        if (i_req.valid && i_req.ready) begin
            r_req_type <= i_req.req_type;
            r_side     <= i_req.side;
            r_price    <= i_req.price;
            r_qty      <= i_req.qty;
            r_action   <= i_req.action;
            r_depth    <= i_req.depth;
        end
    end

    // best levels captured at rank zero for the summary
    assign o_res.valid       = r_out_valid;
    assign o_res.item_kind   = r_out.item_kind;
    assign o_res.status      = r_out.status;
    assign o_res.level_index = r_out.level_index;
    assign o_res.level_price = r_out.level_price;
    assign o_res.level_qty   = r_out.level_qty;
    assign o_res.spread      = r_out.spread;
    assign o_res.mid_doubled = r_out.mid_doubled;
    assign o_res.last        = r_out.last;
endmodule

// File: src/plb_checker.sv
// plb_checker: port-level properties of the price level book
// depends on plb_pkg; bound to price_level_book
module plb_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_req_valid,
    input logic       i_req_ready,
    input logic       o_res_valid,
    input logic       o_res_ready,
    input logic [1:0] o_item_kind,
    input logic       o_status,
    input logic       o_last
);
    import plb_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !o_res_ready |=> o_res_valid)
        else $error("result dropped while stalled");
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && (o_item_kind == KIND_ACK || o_item_kind == KIND_SUM) |-> o_last)
        else $error("ack or summary without last");
    a_lvl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && (o_item_kind == KIND_BID || o_item_kind == KIND_ASK)
        |-> !o_last && !o_status)
        else $error("level item flags wrong");
    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("two requests taken back to back");
endmodule

bind price_level_book plb_checker u_plb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .o_res_valid (o_res.valid),
    .o_res_ready (o_res.ready),
    .o_item_kind (o_res.item_kind),
    .o_status    (o_res.status),
    .o_last      (o_res.last)
);
